/* design/aip_pkg.sv */
// Shared types and constants for the ASCII integer parser.
// Used by every module of the block; depends on nothing else.
package aip_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned VAL_W      = 64;
  localparam int unsigned DIG_W      = 4;
  localparam int unsigned ERR_W      = 2;
  localparam int unsigned IN_TDATA_W = 8;
  // value, then error_code, padded to whole bytes
  localparam int unsigned OUT_TDATA_W = ((VAL_W + ERR_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - VAL_W - ERR_W;

  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_ONE   = 8'h31;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_A_LC  = 8'h61;
  localparam logic [CH_W-1:0] CH_F_LC  = 8'h66;
  localparam logic [CH_W-1:0] CH_X_LC  = 8'h78;
  localparam logic [CH_W-1:0] CH_X_UC  = 8'h58;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CH_BLANK = 8'h20;

  // 'a' has low nibble 1; adding 9 gives its digit value 10
  localparam logic [DIG_W-1:0] HEX_LC_OFS = 4'd9;

  typedef enum logic [6:0] {
    ST_START = 7'b000_0001,
    ST_ZERO  = 7'b000_0010,
    ST_DEC   = 7'b000_0100,
    ST_NEG   = 7'b000_1000,
    ST_X     = 7'b001_0000,
    ST_HEX   = 7'b010_0000,
    ST_BLANK = 7'b100_0000
  } pstate_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE = 2'd0,
    ERR_CHAR = 2'd1,
    ERR_UOVF = 2'd2,
    ERR_SOVF = 2'd3
  } err_e;

  typedef struct packed {
    pstate_e          st;
    logic [VAL_W-1:0] acc;
    logic             neg;
    err_e             err;
  } pctx_t;

  localparam pctx_t CTX_RESET = '{st: ST_START, acc: '0, neg: 1'b0, err: ERR_NONE};

endpackage

/* design/aip_in_stage.sv */
// Input register of the parser: holds one accepted character and its last flag.
// Depends on aip_pkg.
module aip_in_stage
  import aip_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // [7:0] ch
  input  logic                  s_axis_tlast,   // is_last
  input  logic                  take_i,
  output logic                  valid_o,
  output logic [CH_W-1:0]       ch_o,
  output logic                  last_o
);

  logic            valid_q, valid_d;
  logic [CH_W-1:0] ch_q;
  logic            last_q;
  logic            load;

  assign s_axis_tready = !valid_q || take_i;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ch_q   <= s_axis_tdata[CH_W-1:0];
      last_q <= s_axis_tlast;
    end
  end

  assign valid_o = valid_q;
  assign ch_o    = ch_q;
  assign last_o  = last_q;

endmodule

/* design/aip_step.sv */
// One parser step: next parse state, accumulator and error for one character.
// Pure combinational logic; depends on aip_pkg.
module aip_step
  import aip_pkg::*;
(
  input  pctx_t           cur_i,
  input  logic [CH_W-1:0] ch_i,
  output pctx_t           nxt_o
);

  logic               is_dec, is_nz, is_hex_lc, is_x;
  logic [DIG_W-1:0]   dec_d, hex_d;
  logic [VAL_W+3:0]   mul10;
  logic               dec_ovf, hex_ovf;

  assign is_dec    = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign is_nz     = (ch_i >= CH_ONE) && (ch_i <= CH_NINE);
  assign is_hex_lc = (ch_i >= CH_A_LC) && (ch_i <= CH_F_LC);
  assign is_x      = (ch_i == CH_X_LC) || (ch_i == CH_X_UC);

  assign dec_d = ch_i[DIG_W-1:0];
  assign hex_d = is_dec ? dec_d : ch_i[DIG_W-1:0] + HEX_LC_OFS;

  // acc * 10 + d as acc * 8 + acc * 2 + d, carries kept for an exact overflow test
  assign mul10   = {1'b0, cur_i.acc, 3'b000} + {3'b000, cur_i.acc, 1'b0}
                 + {{VAL_W{1'b0}}, dec_d};
  assign dec_ovf = |mul10[VAL_W+3:VAL_W];
  assign hex_ovf = |cur_i.acc[VAL_W-1:VAL_W-DIG_W];

  always_comb begin
    nxt_o = cur_i;
    // sticky error: ignore the rest of the string
    if (cur_i.err == ERR_NONE) begin
      unique case (cur_i.st)
        ST_START: begin
          priority if (ch_i == CH_ZERO) begin
            nxt_o.st  = ST_ZERO;
            nxt_o.acc = '0;
          end else if (is_nz) begin
            nxt_o.st  = ST_DEC;
            nxt_o.acc = {{(VAL_W-DIG_W){1'b0}}, dec_d};
          end else if (ch_i == CH_MINUS) begin
            nxt_o.st  = ST_NEG;
            nxt_o.neg = 1'b1;
          end else begin
            // hold on a leading blank
            if (ch_i != CH_BLANK) nxt_o.err = ERR_CHAR;
          end
        end
        ST_ZERO: begin
          priority if (is_x) begin
            nxt_o.st = ST_X;
          end else if (is_dec) begin
            nxt_o.st = ST_DEC;
            if (dec_ovf) nxt_o.err = ERR_UOVF;
            else         nxt_o.acc = mul10[VAL_W-1:0];
          end else if (ch_i == CH_BLANK) begin
            nxt_o.st = ST_BLANK;
          end else begin
            nxt_o.err = ERR_CHAR;
          end
        end
        ST_DEC: begin
          if (is_dec) begin
            if (dec_ovf) nxt_o.err = ERR_UOVF;
            else         nxt_o.acc = mul10[VAL_W-1:0];
          end else begin
            nxt_o.err = ERR_CHAR;
          end
        end
        ST_NEG: begin
          priority if (is_nz) begin
            nxt_o.st  = ST_DEC;
            nxt_o.acc = {{(VAL_W-DIG_W){1'b0}}, dec_d};
          end else if (ch_i == CH_ZERO) begin
            nxt_o.st = ST_ZERO;
          end else begin
            nxt_o.err = ERR_CHAR;
          end
        end
        ST_X, ST_HEX: begin
          if (is_dec || is_hex_lc) begin
            nxt_o.st = ST_HEX;
            if (hex_ovf) nxt_o.err = ERR_UOVF;
            else         nxt_o.acc = {cur_i.acc[VAL_W-DIG_W-1:0], hex_d};
          end else begin
            nxt_o.err = ERR_CHAR;
          end
        end
        ST_BLANK: begin
          if (ch_i != CH_BLANK) nxt_o.err = ERR_CHAR;
        end
        default: begin
          nxt_o.err = ERR_CHAR;
        end
      endcase
    end
  end

endmodule

/* design/aip_out_stage.sv */
// Result register: applies the sign, signed overflow check and error zeroing.
// Depends on aip_pkg.
module aip_out_stage
  import aip_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fin_valid_i,
  input  pctx_t                  fin_ctx_i,
  output logic                   fin_ready_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [63:0] value, [65:64] error_code
);

  logic             valid_q, valid_d;
  logic [VAL_W-1:0] value_q, value_d;
  err_e             code_q, code_d;
  logic             load;

  assign fin_ready_o = !valid_q || m_axis_tready;
  assign load        = fin_valid_i && fin_ready_o;

  always_comb begin
    value_d = '0;
    code_d  = fin_ctx_i.err;
    if (fin_ctx_i.err == ERR_NONE) begin
      if (!fin_ctx_i.neg) begin
        value_d = fin_ctx_i.acc;
      end else if (fin_ctx_i.acc[VAL_W-1]) begin
        code_d = ERR_SOVF;
      end else begin
        value_d = '0 - fin_ctx_i.acc;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q <= value_d;
      code_q  <= code_d;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, code_q, value_q};

endmodule

/* design/ascii_integer_parser.sv */
// Top level of the ASCII integer parser: input register, parse step, final
// context register and result register. Depends on aip_pkg, aip_in_stage,
// aip_step and aip_out_stage.
//
//   channel  direction  bits  contents
//   s_axis   in         8+1   tdata[7:0] ch, tlast is_last
//   m_axis   out        72    tdata[63:0] value, tdata[65:64] error_code
//
// One character is taken per cycle unless a stalled result holds back a last
// character. A string's result passes the input register, the parse step into
// the final context register, and sign and overflow handling into the result
// register. The decimal multiply-add (acc * 8 + acc * 2 + digit) sets the cycle
// time. Reset clears the parse context and all valid flags. A stalled result
// holds the pipe only behind a last character; other characters keep flowing.
module ascii_integer_parser
  import aip_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] ch
  input  logic                   s_axis_tlast,   // is_last
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [63:0] value, [65:64] error_code
);

  logic            in_valid, in_last, take;
  logic [CH_W-1:0] in_ch;
  pctx_t           ctx_q, ctx_d, ctx_nxt;
  logic            fin_valid_q, fin_valid_d, fin_ready;
  pctx_t           fin_ctx_q;
  logic            fin_free;

  aip_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .take_i        (take),
    .valid_o       (in_valid),
    .ch_o          (in_ch),
    .last_o        (in_last)
  );

  aip_step u_step (
    .cur_i (ctx_q),
    .ch_i  (in_ch),
    .nxt_o (ctx_nxt)
  );

  // only a last character needs room in the final context register
  assign fin_free = !fin_valid_q || fin_ready;
  assign take     = in_valid && (!in_last || fin_free);

  always_comb begin
    ctx_d = ctx_q;
    if (take) begin
      ctx_d = in_last ? CTX_RESET : ctx_nxt;
    end
  end

  always_comb begin
    fin_valid_d = fin_valid_q;
    if (take && in_last) begin
      fin_valid_d = 1'b1;
    end else if (fin_ready) begin
      fin_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q       <= CTX_RESET;
      fin_valid_q <= 1'b0;
    end else begin
      ctx_q       <= ctx_d;
      fin_valid_q <= fin_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_last) begin
      fin_ctx_q <= ctx_nxt;
    end
  end

  aip_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fin_valid_i   (fin_valid_q),
    .fin_ctx_i     (fin_ctx_q),
    .fin_ready_o   (fin_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* tb/sv/ascii_integer_parser_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for ascii_integer_parser: drives strings one character per item,
// predicts each string's value and error code, and checks every result item.
// Depends on aip_pkg and the ascii_integer_parser RTL.
module ascii_integer_parser_test;
  import aip_pkg::*;

  localparam int unsigned ITEMS      = 1250;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    err_e             code;
  } parse_result_t;

  typedef struct {
    string            text;
    bit               typed;
    logic [VAL_W-1:0] value;
    err_e             code;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] ch
  logic                   s_axis_tlast;   // is_last
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [63:0] value, [65:64] error_code

  // Shadow parse context
  pstate_e          exp_state;
  logic [VAL_W-1:0] exp_acc;
  bit               exp_neg;
  err_e             exp_err;

  parse_result_t pending_results[$];
  logic [7:0]    text_q[$];
  int unsigned   live_chars;
  int unsigned   bad_cnt;
  int unsigned   idle_cycles;
  int unsigned   rdy_left;
  bit            src_calm;

  ascii_integer_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  dir_row_t dir_rows [22] = '{
    '{"0",                     1'b1, 64'd0,                  ERR_NONE},
    '{" ",                     1'b1, 64'd0,                  ERR_NONE},
    '{"-",                     1'b1, 64'd0,                  ERR_NONE},
    '{"0x",                    1'b1, 64'd0,                  ERR_NONE},
    '{"18446744073709551615",  1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ERR_NONE},
    '{"18446744073709551616",  1'b1, 64'd0,                  ERR_UOVF},
    '{"0xffffffffffffffff",    1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ERR_NONE},
    '{"0x10000000000000000",   1'b1, 64'd0,                  ERR_UOVF},
    '{"-0x8000000000000000",   1'b1, 64'd0,                  ERR_SOVF},
    '{"-18446744073709551615", 1'b1, 64'd0,                  ERR_SOVF},
    '{"-1",                    1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ERR_NONE},
    '{"-0",                    1'b1, 64'd0,                  ERR_NONE},
    '{"0   ",                  1'b1, 64'd0,                  ERR_NONE},
    '{"0 1",                   1'b1, 64'd0,                  ERR_CHAR},
    '{"0XaF",                  1'b1, 64'd0,                  ERR_CHAR},
    '{"0xg",                   1'b1, 64'd0,                  ERR_CHAR},
    '{"9z9",                   1'b1, 64'd0,                  ERR_CHAR},
    '{"\377",                  1'b1, 64'd0,                  ERR_CHAR},
    '{"-9223372036854775807",  1'b0, 64'd0,                  ERR_NONE},
    '{"  -42",                 1'b0, 64'd0,                  ERR_NONE},
    '{"007",                   1'b0, 64'd0,                  ERR_NONE},
    '{"0x00000000000000001",   1'b0, 64'd0,                  ERR_NONE}
  };

  function automatic void add_decimal(logic [7:0] d);
    if (exp_acc > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'd10) exp_err = ERR_UOVF;
    else exp_acc = exp_acc * 64'd10 + 64'(d);
  endfunction

  function automatic void add_hex(logic [7:0] d);
    if (exp_acc[63:60] != 4'd0) exp_err = ERR_UOVF;
    else exp_acc = {exp_acc[59:0], d[3:0]};
  endfunction

  // Advance the shadow context by one character; return 1 with the result on a last one.
  function automatic bit predict_parse(input logic [7:0] c, input bit last,
                                       output parse_result_t res);
    logic [7:0] dd;
    logic [7:0] hd;
    bit         dig;
    dd  = c - CH_ZERO;
    hd  = c - CH_A_LC + 8'd10;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    res = '{value: '0, code: ERR_NONE};
    live_chars++;
    if (exp_err == ERR_NONE) begin
      case (exp_state)
        ST_START: begin
          if (c == CH_ZERO) begin
            exp_state = ST_ZERO;
            exp_acc   = '0;
          end else if (c >= CH_ONE && c <= CH_NINE) begin
            exp_state = ST_DEC;
            exp_acc   = 64'(dd);
          end else if (c == CH_MINUS) begin
            exp_state = ST_NEG;
            exp_neg   = 1'b1;
          end else if (c != CH_BLANK) begin
            exp_err = ERR_CHAR;
          end
        end
        ST_ZERO: begin
          if (c == CH_X_LC || c == CH_X_UC) begin
            exp_state = ST_X;
          end else if (dig) begin
            exp_state = ST_DEC;
            add_decimal(dd);
          end else if (c == CH_BLANK) begin
            exp_state = ST_BLANK;
          end else begin
            exp_err = ERR_CHAR;
          end
        end
        ST_DEC: begin
          if (dig) add_decimal(dd);
          else exp_err = ERR_CHAR;
        end
        ST_NEG: begin
          if (c >= CH_ONE && c <= CH_NINE) begin
            exp_state = ST_DEC;
            exp_acc   = 64'(dd);
          end else if (c == CH_ZERO) begin
            exp_state = ST_ZERO;
          end else begin
            exp_err = ERR_CHAR;
          end
        end
        ST_X, ST_HEX: begin
          if (dig) begin
            exp_state = ST_HEX;
            add_hex(dd);
          end else if (c >= CH_A_LC && c <= CH_F_LC) begin
            exp_state = ST_HEX;
            add_hex(hd);
          end else begin
            exp_err = ERR_CHAR;
          end
        end
        ST_BLANK: begin
          if (c != CH_BLANK) exp_err = ERR_CHAR;
        end
        default: exp_err = ERR_CHAR;
      endcase
    end
    if (!last) return 1'b0;
    res.code = exp_err;
    if (exp_err == ERR_NONE) begin
      if (!exp_neg) res.value = exp_acc;
      else if (exp_acc[63]) res.code = ERR_SOVF;
      else res.value = -exp_acc;
    end
    exp_state = ST_START;
    exp_acc   = '0;
    exp_neg   = 1'b0;
    exp_err   = ERR_NONE;
    return 1'b1;
  endfunction

  // Mostly back-to-back, sometimes a few cycles, rarely a long hold.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_char(input logic [7:0] c, input bit last, input bit typed,
                           input parse_result_t fixed);
    parse_result_t res;
    int unsigned   gap;
    gap = src_calm ? 0 : gap_len();
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    s_axis_tlast  = last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (predict_parse(c, last, res)) pending_results.push_back(typed ? fixed : res);
    @(negedge clk_i);
  endtask

  // Hold the sender until every pending result has come out.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic push_text(input string t);
    for (int i = 0; i < t.len(); i++) text_q.push_back(t[i]);
  endtask

  function automatic logic [7:0] dec_char();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    return (v < 10) ? CH_ZERO + 8'(v) : CH_A_LC + 8'(v - 10);
  endfunction

  // Fill text_q with one random string: mostly well-formed, some broken, some noise.
  task automatic build_string();
    int unsigned kind;
    int unsigned r;
    int unsigned n;
    int unsigned pos;
    bit          hex_form;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      n = $urandom_range(1, 4);
      repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) text_q.push_back(CH_BLANK);
    if ($urandom_range(0, 3) == 0) text_q.push_back(CH_MINUS);
    if (kind >= 60 && kind < 68) begin
      text_q.push_back(CH_ZERO);
      repeat ($urandom_range(0, 3)) text_q.push_back(CH_BLANK);
      return;
    end
    hex_form = (kind >= 35 && kind < 60) || (kind >= 68 && $urandom_range(0, 1) == 1);
    r = $urandom_range(0, 9);
    if (hex_form) begin
      text_q.push_back(CH_ZERO);
      text_q.push_back($urandom_range(0, 1) ? CH_X_LC : CH_X_UC);
      if (r == 0) begin
        push_text("8000000000000000");
      end else begin
        n = (r < 3) ? $urandom_range(15, 17) : $urandom_range(0, 8);
        repeat (n) text_q.push_back(hex_char());
      end
    end else begin
      // Near the unsigned and signed limits, the last digit decides
      if (r == 0) push_text("1844674407370955161");
      else if (r == 1) push_text("922337203685477580");
      else if ($urandom_range(0, 4) == 0) text_q.push_back(CH_ZERO);
      n = (r < 2) ? 1 : (r < 4) ? $urandom_range(17, 21) : $urandom_range(1, 6);
      repeat (n) text_q.push_back(dec_char());
    end
    if (kind >= 68) begin
      pos = $urandom_range(0, text_q.size() - 1);
      text_q[pos] = 8'($urandom_range(0, 255));
    end
  endtask

  // Result side: random stall patterns with occasional long ready stretches.
  always @(negedge clk_i) begin
    if (rdy_left != 0) begin
      rdy_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      m_axis_tready = 1'b1;
      rdy_left      = $urandom_range(40, 150);
    end else begin
      m_axis_tready = ($urandom_range(0, 2) != 0);
      rdy_left      = gap_len();
    end
  end

  always @(posedge clk_i) begin
    parse_result_t    want;
    logic [VAL_W-1:0] got_value;
    logic [ERR_W-1:0] got_code;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_value = m_axis_tdata[VAL_W-1:0];
      got_code  = m_axis_tdata[VAL_W +: ERR_W];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, value %h, error_code %0d", $time, got_value,
                 got_code);
        bad_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got_value !== want.value) begin
          $display("%0t: value mismatch, expected %h, got %h", $time, want.value, got_value);
          bad_cnt++;
        end
        if (got_code !== want.code) begin
          $display("%0t: error_code mismatch, expected %0d, got %0d", $time, want.code,
                   got_code);
          bad_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    parse_result_t fixed;
    parse_result_t no_res;
    int unsigned   len;
    int unsigned   str_cnt;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    rdy_left      = 0;
    src_calm      = 1'b0;
    live_chars    = 0;
    bad_cnt       = 0;
    idle_cycles   = 0;
    str_cnt       = 0;
    no_res        = '{value: '0, code: ERR_NONE};
    exp_state     = ST_START;
    exp_acc       = '0;
    exp_neg       = 1'b0;
    exp_err       = ERR_NONE;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[r]) begin
      fixed    = '{value: dir_rows[r].value, code: dir_rows[r].code};
      len      = dir_rows[r].text.len();
      src_calm = r[0];
      for (int i = 0; i < len; i++) begin
        send_char(dir_rows[r].text[i], i == len - 1, dir_rows[r].typed, fixed);
      end
    end
    drain();

    while (live_chars < ITEMS) begin
      build_string();
      src_calm = ($urandom_range(0, 3) == 0);
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1, 1'b0, no_res);
      str_cnt++;
      if (str_cnt % 50 == 0) drain();
    end
    drain();
    repeat (12) @(posedge clk_i);

    if (bad_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
